// ===== src/accel_limited_trajectory_limiter_top_defines.svh =====
// Assertion macros used by the limiter's top RTL file.
`ifndef ACCEL_LIMITED_TRAJECTORY_LIMITER_TOP_DEFINES_SVH
`define ACCEL_LIMITED_TRAJECTORY_LIMITER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, gated by the active-low reset.
`define ALTL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("altl assertion failed");
// Next-cycle implication, gated by the active-low reset.
`define ALTL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("altl assertion failed");
`else
`define ALTL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ALTL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/altl_pkg.sv =====
`timescale 1ns / 1ps
package altl_pkg;
    localparam int POS_W  = 32;
    localparam int CFG_W  = 31;
    localparam int DIST_W = 64;

    localparam logic [CFG_W-1:0] MAX_STEP_SPEED_RST = 31'd66;
    localparam logic [CFG_W-1:0] STEP_ACCEL_RST     = 31'd1;

    localparam logic REG_MAX_STEP_SPEED = 1'b0;
    localparam logic REG_STEP_ACCEL     = 1'b1;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    typedef struct packed {
        logic             start;
        logic [CFG_W-1:0] speed;
        logic [CFG_W-1:0] accel;
    } t_sd_req;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] stop_len;
    } t_sd_resp;
endpackage

// ===== src/altl_if.sv =====
`timescale 1ns / 1ps
interface altl_in_if;
    import altl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [POS_W-1:0] target_or_position;
    modport source (output valid, output op, output target_or_position, input ready);
    modport sink   (input valid, input op, input target_or_position, output ready);
endinterface

interface altl_out_if;
    import altl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] step_velocity;
    logic                    settled;
    modport source (output valid, output position, output step_velocity, output settled,
                    input ready);
    modport sink   (input valid, input position, input step_velocity, input settled,
                    output ready);
endinterface

interface altl_cfg_if;
    import altl_pkg::*;
    logic             valid;
    logic             ready;
    logic             index;
    logic [POS_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/accel_limited_trajectory_limiter_top.sv =====
// A move that accelerates or brakes waits for a stop-distance computation (a
// divide, then two shift-add multiplies); a place op, a first target or an exact
// landing skips it. One word at a time.
// Reset (synchronous, active low): position and velocity 0, uninitialized,
// max_step_speed 66, step_accel 1, output empty.
`timescale 1ns / 1ps
`include "accel_limited_trajectory_limiter_top_defines.svh"
module accel_limited_trajectory_limiter_top (
    input logic        i_clk,
    input logic        i_rst_n,
    altl_in_if.sink    i_in,
    altl_out_if.source o_out,
    altl_cfg_if.sink   i_cfg
);
    import altl_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SDWAIT = 3'd3;
    localparam logic [2:0] S_VEL    = 3'd4;
    localparam logic [2:0] S_POS    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]              r_state;
    logic [CFG_W-1:0]        r_max_speed;
    logic [CFG_W-1:0]        r_accel;
    logic                    r_op;
    logic signed [POS_W-1:0] r_tgt;
    logic signed [POS_W-1:0] r_pos;
    logic signed [POS_W-1:0] r_vel;
    logic                    r_init;
    logic                    r_settled;
    logic signed [POS_W:0]   r_rem;
    logic                    r_go;
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_out_pos;
    logic signed [POS_W-1:0] r_out_vel;
    logic                    r_out_settled;

    logic [CFG_W-1:0]        w_acc_eff;
    logic [POS_W:0]          w_arem;
    logic signed [POS_W+1:0] w_rv;
    logic [POS_W+1:0]        w_rv_mag;
    logic                    w_land;
    logic [POS_W-1:0]        w_vel_mag;
    logic [POS_W:0]          w_vnext;
    logic [CFG_W-1:0]        w_vtest;
    logic signed [POS_W+1:0] w_vel_x;
    logic signed [POS_W+1:0] w_acc_x;
    logic signed [POS_W+1:0] w_vmax_x;
    logic signed [POS_W+1:0] w_vnew;
    logic signed [POS_W+1:0] w_vclamp;
    logic signed [POS_W+1:0] w_psum;
    logic signed [POS_W-1:0] w_pclamp;
    logic                    w_out_load;
    t_sd_req                 w_sd_req;
    t_sd_resp                w_sd_resp;

    always_comb begin
        w_acc_eff = (r_accel == '0) ? {{(CFG_W-1){1'b0}}, 1'b1} : r_accel;
        w_arem    = r_rem[POS_W] ? (~r_rem + 1'b1) : r_rem;
        w_rv      = {r_rem[POS_W], r_rem} - {{2{r_vel[POS_W-1]}}, r_vel};
        w_rv_mag  = w_rv[POS_W+1] ? (~w_rv + 1'b1) : w_rv;
        w_land    = (w_arem <= {2'b0, w_acc_eff}) && (w_arem <= {2'b0, r_max_speed})
                    && (w_rv_mag <= {3'b0, w_acc_eff});
        w_vel_mag = r_vel[POS_W-1] ? (~r_vel + 1'b1) : r_vel;
        w_vnext   = {1'b0, w_vel_mag} + {2'b0, w_acc_eff};
        w_vtest   = (w_vnext < {2'b0, r_max_speed}) ? w_vnext[CFG_W-1:0] : r_max_speed;

        w_vel_x  = {{2{r_vel[POS_W-1]}}, r_vel};
        w_acc_x  = {3'b0, w_acc_eff};
        w_vmax_x = {3'b0, r_max_speed};
        if (r_go) begin
            if (!r_rem[POS_W] && (r_rem != '0)) begin
                w_vnew = w_vel_x + w_acc_x;
            end else if (r_rem[POS_W]) begin
                w_vnew = w_vel_x - w_acc_x;
            end else begin
                w_vnew = w_vel_x;
            end
        end else begin
            // brake toward zero, never through it
            if ({1'b0, w_vel_mag} <= {2'b0, w_acc_eff}) begin
                w_vnew = '0;
            end else if (!r_vel[POS_W-1]) begin
                w_vnew = w_vel_x - w_acc_x;
            end else begin
                w_vnew = w_vel_x + w_acc_x;
            end
        end
        if (w_vnew > w_vmax_x) begin
            w_vclamp = w_vmax_x;
        end else if (w_vnew < -w_vmax_x) begin
            w_vclamp = -w_vmax_x;
        end else begin
            w_vclamp = w_vnew;
        end

        w_psum = {{2{r_pos[POS_W-1]}}, r_pos} + {{2{r_vel[POS_W-1]}}, r_vel};
        if (w_psum > $signed({3'b0, {(POS_W-1){1'b1}}})) begin
            w_pclamp = {1'b0, {(POS_W-1){1'b1}}};
        end else if (w_psum < $signed({3'b111, {(POS_W-1){1'b0}}})) begin
            w_pclamp = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            w_pclamp = w_psum[POS_W-1:0];
        end

        w_sd_req.start = (r_state == S_DECIDE) && (r_op == OP_STEP) && r_init && !w_land;
        w_sd_req.speed = w_vtest;
        w_sd_req.accel = w_acc_eff;

        w_out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
    end

    altl_stopdist u_stopdist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sd_req),
        .o_resp  (w_sd_resp)
    );

    always_ff @(posedge i_clk) begin
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAX_STEP_SPEED: r_max_speed <= i_cfg.data[CFG_W-1:0];
                REG_STEP_ACCEL:     r_accel     <= i_cfg.data[CFG_W-1:0];
                default:            r_accel     <= r_accel;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_op    <= i_in.op;
                    r_tgt   <= i_in.target_or_position;
                    r_state <= S_PREP;
                end
            end
            S_PREP: begin
                r_rem   <= {r_tgt[POS_W-1], r_tgt} - {r_pos[POS_W-1], r_pos};
                r_state <= S_DECIDE;
            end
            S_DECIDE: begin
                if (r_op == OP_PLACE) begin
                    r_pos     <= r_tgt;
                    r_vel     <= '0;
                    r_settled <= 1'b0;
                    r_init    <= 1'b1;
                    r_state   <= S_OUT;
                end else if (!r_init) begin
                    r_pos     <= r_tgt;
                    r_vel     <= '0;
                    r_settled <= 1'b1;
                    r_init    <= 1'b1;
                    r_state   <= S_OUT;
                end else if (w_land) begin
                    r_vel     <= r_rem[POS_W-1:0];
                    r_pos     <= r_tgt;
                    r_settled <= (r_rem == '0);
                    r_state   <= S_OUT;
                end else begin
                    r_state <= S_SDWAIT;
                end
            end
            S_SDWAIT: begin
                if (w_sd_resp.done) begin
                    r_go    <= ({{(DIST_W-POS_W-1){1'b0}}, w_arem} >= w_sd_resp.stop_len);
                    r_state <= S_VEL;
                end
            end
            S_VEL: begin
                r_vel   <= w_vclamp[POS_W-1:0];
                r_state <= S_POS;
            end
            S_POS: begin
                r_pos     <= w_pclamp;
                r_settled <= 1'b0;
                r_state   <= S_OUT;
            end
            S_OUT: begin
                if (w_out_load) begin
                    r_state <= S_IDLE;
                end
            end
            default: r_state <= S_IDLE;
        endcase

        if (w_out_load) begin
            r_out_valid   <= 1'b1;
            r_out_pos     <= r_pos;
            r_out_vel     <= r_vel;
            r_out_settled <= r_init && r_settled;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_speed <= MAX_STEP_SPEED_RST;
            r_accel     <= STEP_ACCEL_RST;
            r_pos       <= '0;
            r_vel       <= '0;
            r_init      <= 1'b0;
            r_settled   <= 1'b0;
            r_out_valid <= 1'b0;
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.position      = r_out_pos;
    assign o_out.step_velocity = r_out_vel;
    assign o_out.settled       = r_out_settled;

    `ALTL_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state != S_IDLE)
    `ALTL_ASSERT_IMP(a_settled_still, i_clk, i_rst_n, o_out.valid && o_out.settled, o_out.step_velocity == '0)
    `ALTL_ASSERT_IMP(a_sd_done_wait, i_clk, i_rst_n, w_sd_resp.done, r_state == S_SDWAIT)
endmodule

// ===== src/altl_stopdist.sv =====
`timescale 1ns / 1ps
module altl_stopdist (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  altl_pkg::t_sd_req i_req,
    output altl_pkg::t_sd_resp o_resp
);
    import altl_pkg::*;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_DIV  = 2'd1;
    localparam logic [1:0] P_MUL1 = 2'd2;
    localparam logic [1:0] P_MUL2 = 2'd3;

    logic [1:0]        r_phase;
    logic [4:0]        r_cnt;
    logic              r_done;
    logic [CFG_W-1:0]  r_a;
    logic [CFG_W-1:0]  r_v;
    logic [CFG_W-1:0]  r_rem;
    logic [31:0]       r_quo;
    logic [31:0]       r_n;
    logic [63:0]       r_mc;
    logic [31:0]       r_mp;
    logic [63:0]       r_acc;
    logic [DIST_W-1:0] r_dist;

    logic [31:0] w_trial;
    logic        w_qbit;
    logic [31:0] w_trial_sub;
    logic [31:0] w_n;
    logic [63:0] w_sum;
    logic [63:0] w_w;

    always_comb begin
        w_trial     = {r_rem, r_quo[31]};
        w_qbit      = (w_trial >= {1'b0, r_a});
        w_trial_sub = w_trial - {1'b0, r_a};
        w_n         = {r_quo[30:0], w_qbit};
        w_sum       = r_acc + (r_mp[0] ? r_mc : 64'd0);
        // 2v - a(n-1): positive whenever n is nonzero
        w_w         = {32'd0, r_v, 1'b0} - w_sum;
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        case (r_phase)
            P_IDLE: begin
                if (i_req.start) begin
                    r_a     <= i_req.accel;
                    r_v     <= i_req.speed;
                    r_quo   <= {1'b0, i_req.speed} + {1'b0, i_req.accel} - 32'd1;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_phase <= P_DIV;
                end
            end
            P_DIV: begin
                r_rem <= w_qbit ? w_trial_sub[CFG_W-1:0] : w_trial[CFG_W-1:0];
                r_quo <= w_n;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_n     <= w_n;
                    r_mc    <= {33'd0, r_a};
                    r_mp    <= w_n - 32'd1;
                    r_acc   <= '0;
                    r_phase <= P_MUL1;
                end
            end
            P_MUL1: begin
                r_acc <= w_sum;
                r_mc  <= {r_mc[62:0], 1'b0};
                r_mp  <= {1'b0, r_mp[31:1]};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_mc    <= w_w;
                    r_mp    <= r_n;
                    r_acc   <= '0;
                    r_phase <= P_MUL2;
                end
            end
            P_MUL2: begin
                r_acc <= w_sum;
                r_mc  <= {r_mc[62:0], 1'b0};
                r_mp  <= {1'b0, r_mp[31:1]};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_dist  <= {1'b0, w_sum[63:1]};
                    r_done  <= 1'b1;
                    r_phase <= P_IDLE;
                end
            end
            default: r_phase <= P_IDLE;
        endcase
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end
    end

    assign o_resp.done     = r_done;
    assign o_resp.stop_len = r_dist;
endmodule
